@@ hw/rtl/modbus_rtu_master_frame_engine_defines.svh @@
// Assertion macros used by the frame engine port-level checker
`ifndef MODBUS_RTU_MASTER_FRAME_ENGINE_DEFINES_SVH
`define MODBUS_RTU_MASTER_FRAME_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRFE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, sampled on clk, off during reset
`define MRFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/mrfe_pkg.sv @@
// Types, codes and the CRC-16 helper of the Modbus RTU master frame engine
package mrfe_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_RX    = 2'd2;

	localparam logic OUT_TX   = 1'b0;
	localparam logic OUT_DONE = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
	localparam logic [1:0] STATUS_ECHO_BAD = 2'd2;

	localparam logic [7:0]  FC_READ_HOLD    = 8'h03;
	localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] READ_COUNT      = 16'h0001;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] READ_FAIL_VALUE = 16'hFFFF;

	localparam int CMD_FIFO_DEPTH = 4;
	localparam int RES_FIFO_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  unit_addr;
		logic [15:0] hreg_addr;
		logic [15:0] reg_value;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [1:0]  status;
		logic [15:0] read_value;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_BYTE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  slave;
		logic [15:0] hreg_addr;
		logic [15:0] data;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/mrfe_fifo.sv @@
// Small synchronous first-word-fall-through FIFO
module mrfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ hw/rtl/mrfe_front.sv @@
// Front end: takes input items, classifies them and queues commands
module mrfe_front #(
	parameter int CMD_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mrfe_pkg::in_item_t item,
	input  logic              cmd_pop,
	output mrfe_pkg::cmd_t    cmd,
	output logic              cmd_empty
);
	import mrfe_pkg::*;

	cmd_t cmd_in;
	logic keep;
	logic cmd_push;
	logic cmd_full;

	always_comb begin
		cmd_in.kind      = CMD_BYTE;
		cmd_in.slave     = item.unit_addr;
		cmd_in.hreg_addr = item.hreg_addr;
		cmd_in.data      = {8'h00, item.rx_byte};
		keep             = 1'b1;
		case (item.req_type)
			REQ_READ: begin
				cmd_in.kind = CMD_READ;
				cmd_in.data = READ_COUNT;
			end
			REQ_WRITE: begin
				cmd_in.kind = CMD_WRITE;
				cmd_in.data = item.reg_value;
			end
			REQ_RX: begin
				cmd_in.kind = CMD_BYTE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full && keep;

	mrfe_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

@@ hw/rtl/mrfe_back.sv @@
// Back end: frame transmit with CRC, response check and completion
module mrfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  mrfe_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output mrfe_pkg::out_item_t res
);
	import mrfe_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_WRITE
	} phase_t;

	phase_t      phase_q;
	logic        tx_active_q;
	logic [2:0]  tx_idx_q;
	logic [15:0] crc_tx_q;
	cmd_t        hold_q;
	logic [7:0]  sent_frame_q [8];
	logic [2:0]  rx_count_q;
	logic [15:0] crc_acc_q;
	logic [15:0] data_word_q;
	logic [7:0]  crc_low_q;
	logic        echo_bad_q;

	logic        can_go;
	logic [7:0]  tx_byte_w;
	logic [7:0]  fn_code;
	logic [7:0]  rx_b;
	logic        is_req;
	logic        read_done;
	logic        write_done;
	logic        echo_diff;

	assign can_go  = !res_full;
	assign cmd_pop = !tx_active_q && !cmd_empty && can_go;
	assign fn_code = (hold_q.kind == CMD_READ) ? FC_READ_HOLD : FC_WRITE_SINGLE;
	assign rx_b    = cmd.data[7:0];
	assign is_req  = (cmd.kind == CMD_READ) || (cmd.kind == CMD_WRITE);
	assign read_done  = (cmd.kind == CMD_BYTE) && (phase_q == PH_READ) && (rx_count_q == 3'd6);
	assign write_done = (cmd.kind == CMD_BYTE) && (phase_q == PH_WRITE) && (rx_count_q == 3'd7);
	assign echo_diff  = (rx_b != sent_frame_q[rx_count_q]);

	always_comb begin
		case (tx_idx_q)
			3'd1:    tx_byte_w = fn_code;
			3'd2:    tx_byte_w = hold_q.hreg_addr[15:8];
			3'd3:    tx_byte_w = hold_q.hreg_addr[7:0];
			3'd4:    tx_byte_w = hold_q.data[15:8];
			3'd5:    tx_byte_w = hold_q.data[7:0];
			3'd6:    tx_byte_w = crc_tx_q[7:0];
			3'd7:    tx_byte_w = crc_tx_q[15:8];
			default: tx_byte_w = hold_q.slave;
		endcase
	end

	always_comb begin
		res      = '0;
		res_push = 1'b0;
		if (tx_active_q) begin
			res_push     = can_go;
			res.out_kind = OUT_TX;
			res.tx_byte  = tx_byte_w;
			res.last     = (tx_idx_q == 3'd7);
		end else if (cmd_pop) begin
			if (is_req) begin
				res_push     = 1'b1;
				res.out_kind = OUT_TX;
				res.tx_byte  = cmd.slave;
			end else if (read_done) begin
				res_push     = 1'b1;
				res.out_kind = OUT_DONE;
				res.last     = 1'b1;
				if ({rx_b, crc_low_q} == crc_acc_q) begin
					res.status     = STATUS_OK;
					res.read_value = data_word_q;
				end else begin
					res.status     = STATUS_CRC_ERR;
					res.read_value = READ_FAIL_VALUE;
				end
			end else if (write_done) begin
				res_push     = 1'b1;
				res.out_kind = OUT_DONE;
				res.last     = 1'b1;
				res.status   = (echo_bad_q || echo_diff) ? STATUS_ECHO_BAD : STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tx_active_q <= 1'b0;
			tx_idx_q    <= '0;
			crc_tx_q    <= CRC_INIT;
			rx_count_q  <= '0;
			crc_acc_q   <= CRC_INIT;
			data_word_q <= '0;
			crc_low_q   <= '0;
			echo_bad_q  <= 1'b0;
		end else if (tx_active_q) begin
			if (can_go) begin
				if (tx_idx_q < 3'd6) begin
					crc_tx_q <= crc_byte(crc_tx_q, tx_byte_w);
				end
				if (tx_idx_q == 3'd7) begin
					tx_active_q <= 1'b0;
				end
				tx_idx_q <= tx_idx_q + 3'd1;
			end
		end else if (cmd_pop) begin
			case (cmd.kind)
				CMD_READ, CMD_WRITE: begin
					phase_q     <= (cmd.kind == CMD_READ) ? PH_READ : PH_WRITE;
					tx_active_q <= 1'b1;
					tx_idx_q    <= 3'd1;
					crc_tx_q    <= crc_byte(CRC_INIT, cmd.slave);
					rx_count_q  <= '0;
					crc_acc_q   <= CRC_INIT;
					data_word_q <= '0;
					crc_low_q   <= '0;
					echo_bad_q  <= 1'b0;
				end
				CMD_BYTE: begin
					case (phase_q)
						PH_READ: begin
							if (rx_count_q < 3'd5) begin
								crc_acc_q <= crc_byte(crc_acc_q, rx_b);
							end
							if (rx_count_q == 3'd3) begin
								data_word_q[15:8] <= rx_b;
							end else if (rx_count_q == 3'd4) begin
								data_word_q[7:0] <= rx_b;
							end else if (rx_count_q == 3'd5) begin
								crc_low_q <= rx_b;
							end
							if (read_done) begin
								phase_q    <= PH_IDLE;
								rx_count_q <= '0;
							end else begin
								rx_count_q <= rx_count_q + 3'd1;
							end
						end
						PH_WRITE: begin
							if (echo_diff) begin
								echo_bad_q <= 1'b1;
							end
							if (write_done) begin
								phase_q    <= PH_IDLE;
								rx_count_q <= '0;
							end else begin
								rx_count_q <= rx_count_q + 3'd1;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tx_active_q && can_go) begin
			sent_frame_q[tx_idx_q] <= tx_byte_w;
		end else if (cmd_pop && is_req) begin
			hold_q          <= cmd;
			sent_frame_q[0] <= cmd.slave;
		end
	end

endmodule

@@ hw/rtl/modbus_rtu_master_frame_engine.sv @@
// Top level of the Modbus RTU master frame engine
//
// Input channel (push/full): read request, write request or received line byte.
// Result channel (empty/pop): transmit bytes and transaction completions, in order.
// A request yields eight transmit bytes (last on the eighth): address, function,
// register, count or value, then CRC-16 low and high. A read completes after the
// seventh response byte with the data word or a CRC error; a write completes after
// the eighth echo byte with ok or echo mismatch. A new request drops any pending
// transaction. Bytes arriving while idle, and request type 3, give no result.
// Throughput: one received byte per cycle while the result queue has room; a
// request holds off new commands until its eight transmit bytes are queued.
// Each item passes through the command queue, then the result queue, before
// its results reach the result ports.
// Stall: while the result queue is full the back end holds; once the command
// queue fills, full rises and no more items are taken.
// Reset: both queues empty, engine idle, no results pending.
module modbus_rtu_master_frame_engine #(
	parameter int CMD_DEPTH = mrfe_pkg::CMD_FIFO_DEPTH,
	parameter int RES_DEPTH = mrfe_pkg::RES_FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mrfe_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output mrfe_pkg::out_item_t result
);
	import mrfe_pkg::*;

	cmd_t      cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	mrfe_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	mrfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	mrfe_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

@@ hw/rtl/mrfe_checker.sv @@
// Port-level checker for the frame engine and its bind
`include "modbus_rtu_master_frame_engine_defines.svh"

module mrfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input mrfe_pkg::in_item_t  item,
	input logic                empty,
	input logic                pop,
	input mrfe_pkg::out_item_t result
);
	import mrfe_pkg::*;

	`MRFE_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result))
	`MRFE_ASSERT_IMPL(a_done_last, !empty && result.out_kind == OUT_DONE, result.last && result.tx_byte == 8'h00)
	`MRFE_ASSERT_IMPL(a_tx_clean, !empty && result.out_kind == OUT_TX, result.status == STATUS_OK && result.read_value == 16'h0000)
	`MRFE_ASSERT_IMPL(a_crc_fail_val, !empty && result.status == STATUS_CRC_ERR, result.read_value == READ_FAIL_VALUE)

endmodule

bind modbus_rtu_master_frame_engine mrfe_checker u_mrfe_checker (.*);

@@ tb/sv/mrfe_frame_checker.sv @@
// Checker for the Modbus RTU master frame engine: predicts transmit bytes and completions
module mrfe_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  mrfe_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  mrfe_pkg::out_item_t result,
	output int                  fail_count,
	output int                  results_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import mrfe_pkg::*;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_READ,
		ENG_WRITE
	} eng_phase_t;

	eng_phase_t  phase;
	logic [3:0]  rx_cnt;
	logic [15:0] rsp_crc;
	logic [7:0]  frame_sent [8];
	logic [15:0] word_rx;
	logic [7:0]  crc_lo;
	logic        echo_err;
	out_item_t   owed_results [$];
	out_item_t   want;

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc ^ {8'h00, d};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void owe_result(input logic kind, input logic [7:0] txb, input logic lst,
			input logic [1:0] st, input logic [15:0] val);
		out_item_t r;
		r.out_kind   = kind;
		r.tx_byte    = txb;
		r.last       = lst;
		r.status     = st;
		r.read_value = val;
		owed_results.push_back(r);
	endfunction

	function automatic void engine_step(input in_item_t it);
		logic [15:0] c;
		logic [3:0]  n;
		logic        is_read;
		is_read = (it.req_type == REQ_READ);
		case (it.req_type)
			REQ_READ, REQ_WRITE: begin
				frame_sent[0] = it.unit_addr;
				frame_sent[1] = is_read ? FC_READ_HOLD : FC_WRITE_SINGLE;
				frame_sent[2] = it.hreg_addr[15:8];
				frame_sent[3] = it.hreg_addr[7:0];
				frame_sent[4] = is_read ? READ_COUNT[15:8] : it.reg_value[15:8];
				frame_sent[5] = is_read ? READ_COUNT[7:0] : it.reg_value[7:0];
				c = CRC_INIT;
				for (int i = 0; i < 6; i++) begin
					c = crc16_step(c, frame_sent[i]);
				end
				frame_sent[6] = c[7:0];
				frame_sent[7] = c[15:8];
				for (int i = 0; i < 8; i++) begin
					owe_result(OUT_TX, frame_sent[i], i == 7, STATUS_OK, 16'h0000);
				end
				phase    = is_read ? ENG_READ : ENG_WRITE;
				rx_cnt   = '0;
				rsp_crc  = CRC_INIT;
				word_rx  = '0;
				crc_lo   = '0;
				echo_err = 1'b0;
			end
			REQ_RX: begin
				n = rx_cnt;
				if (phase == ENG_READ) begin
					if (n < 5) begin
						rsp_crc = crc16_step(rsp_crc, it.rx_byte);
					end
					if (n == 3) begin
						word_rx[15:8] = it.rx_byte;
					end else if (n == 4) begin
						word_rx[7:0] = it.rx_byte;
					end else if (n == 5) begin
						crc_lo = it.rx_byte;
					end
					if (n >= 6) begin
						if ({it.rx_byte, crc_lo} == rsp_crc) begin
							owe_result(OUT_DONE, 8'h00, 1'b1, STATUS_OK, word_rx);
						end else begin
							owe_result(OUT_DONE, 8'h00, 1'b1, STATUS_CRC_ERR, READ_FAIL_VALUE);
						end
						phase  = ENG_IDLE;
						rx_cnt = '0;
					end else begin
						rx_cnt = n + 4'd1;
					end
				end else if (phase == ENG_WRITE) begin
					n = {1'b0, rx_cnt[2:0]};
					if (it.rx_byte != frame_sent[n[2:0]]) begin
						echo_err = 1'b1;
					end
					if (n == 7) begin
						owe_result(OUT_DONE, 8'h00, 1'b1,
							echo_err ? STATUS_ECHO_BAD : STATUS_OK, 16'h0000);
						phase  = ENG_IDLE;
						rx_cnt = '0;
					end else begin
						rx_cnt = n + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase    = ENG_IDLE;
			rx_cnt   = '0;
			rsp_crc  = CRC_INIT;
			word_rx  = '0;
			crc_lo   = '0;
			echo_err = 1'b0;
			owed_results.delete();
			fail_count   = 0;
			results_owed = 0;
		end else begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, result);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("out_kind", 16'(want.out_kind), 16'(result.out_kind));
					check_field("tx_byte", 16'(want.tx_byte), 16'(result.tx_byte));
					check_field("last", 16'(want.last), 16'(result.last));
					check_field("status", 16'(want.status), 16'(result.status));
					check_field("read_value", want.read_value, result.read_value);
				end
			end
			if (push && !full) begin
				engine_step(item);
			end
			results_owed = owed_results.size();
		end
	end

endmodule

@@ tb/sv/tb_modbus_rtu_master_frame_engine.sv @@
// Testbench top for the Modbus RTU master frame engine: stimulus, watchdog and verdict
module tb_modbus_rtu_master_frame_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import mrfe_pkg::*;

	localparam int         ITEM_TARGET     = 200;
	localparam int         WATCHDOG_LIMIT  = 4000;
	localparam int         DRAIN_CYCLES    = 16;
	localparam logic [1:0] REQ_UNUSED      = 2'd3;
	localparam logic [7:0] READ_BYTE_COUNT = 8'd2;

	typedef enum logic [1:0] {
		RSP_GOOD,
		RSP_ODD_SHAPE,
		RSP_CORRUPT,
		RSP_CUT
	} rsp_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;
	int        fail_count;
	int        results_owed;
	int        sent_count = 0;
	int        stall_cycles = 0;
	int        roll;
	logic      quiet = 1'b0;
	logic      pressure_done = 1'b0;

	modbus_rtu_master_frame_engine dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result
	);

	mrfe_frame_checker frame_check (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result,
		.fail_count,
		.results_owed
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		pop <= arst_n && (quiet || $urandom_range(0, 99) >= 27);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] pick8();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.req_type  = 2'($urandom_range(0, 3));
		it.unit_addr = 8'($urandom_range(0, 255));
		it.hreg_addr = 16'($urandom_range(0, 65535));
		it.reg_value = 16'($urandom_range(0, 65535));
		it.rx_byte   = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic rsp_mode_t pick_mode(input int good, input int odd, input int bad);
		int r;
		r = $urandom_range(0, 99);
		if (r < good) begin
			return RSP_GOOD;
		end else if (r < good + odd) begin
			return RSP_ODD_SHAPE;
		end else if (r < good + odd + bad) begin
			return RSP_CORRUPT;
		end
		return RSP_CUT;
	endfunction

	task automatic send_item(input in_item_t it, input bit counted);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 27) begin
				push <= 1'b0;
				@(negedge clk);
			end
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (counted) begin
			sent_count++;
		end
	endtask

	task automatic send_request(input logic [1:0] kind, input logic [7:0] sa,
			input logic [15:0] ra, input logic [15:0] rv);
		in_item_t it;
		it = random_item();
		it.req_type  = kind;
		it.unit_addr = sa;
		it.hreg_addr = ra;
		it.reg_value = rv;
		send_item(it, 1'b1);
	endtask

	task automatic send_rx(input logic [7:0] b, input bit counted);
		in_item_t it;
		it = random_item();
		it.req_type = REQ_RX;
		it.rx_byte  = b;
		send_item(it, counted);
	endtask

	task automatic run_read(input logic [7:0] sa, input logic [15:0] ra, input rsp_mode_t mode);
		logic [7:0]  rsp [7];
		logic [15:0] c;
		int          n;
		int          k;
		send_request(REQ_READ, sa, ra, pick16());
		rsp[0] = sa;
		rsp[1] = FC_READ_HOLD;
		rsp[2] = READ_BYTE_COUNT;
		rsp[3] = pick8();
		rsp[4] = pick8();
		if (mode == RSP_ODD_SHAPE) begin
			for (int j = 0; j < 3; j++) begin
				rsp[j] = pick8();
			end
		end
		c = CRC_INIT;
		for (int j = 0; j < 5; j++) begin
			c = crc_byte(c, rsp[j]);
		end
		rsp[5] = c[7:0];
		rsp[6] = c[15:8];
		if (mode == RSP_CORRUPT) begin
			k = $urandom_range(0, 6);
			rsp[k] = rsp[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		n = (mode == RSP_CUT) ? $urandom_range(0, 6) : 7;
		for (int j = 0; j < n; j++) begin
			send_rx(rsp[j], 1'b1);
		end
	endtask

	task automatic run_write(input logic [7:0] sa, input logic [15:0] ra, input logic [15:0] rv,
			input rsp_mode_t mode);
		logic [7:0]  echo [8];
		logic [15:0] c;
		int          n;
		int          k;
		echo[0] = sa;
		echo[1] = FC_WRITE_SINGLE;
		echo[2] = ra[15:8];
		echo[3] = ra[7:0];
		echo[4] = rv[15:8];
		echo[5] = rv[7:0];
		c = CRC_INIT;
		for (int j = 0; j < 6; j++) begin
			c = crc_byte(c, echo[j]);
		end
		echo[6] = c[7:0];
		echo[7] = c[15:8];
		send_request(REQ_WRITE, sa, ra, rv);
		if (mode == RSP_CORRUPT) begin
			k = $urandom_range(0, 7);
			echo[k] = echo[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		n = (mode == RSP_CUT) ? $urandom_range(0, 7) : 8;
		for (int j = 0; j < n; j++) begin
			send_rx(echo[j], 1'b1);
		end
	endtask

	initial begin
		in_item_t junk;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ignored items: line byte while idle, unused request type
		send_rx(8'hFF, 1'b0);
		send_item('1, 1'b0);
		// oddly shaped reply (random header bytes) with valid CRC still returns its data bytes
		run_read(8'h00, 16'h0000, RSP_ODD_SHAPE);
		run_write(8'hFF, 16'hFFFF, 16'hFFFF, RSP_GOOD);
		// pending read dropped by a new write, then a bad echo
		send_request(REQ_READ, 8'hA5, 16'h5A5A, 16'h0000);
		run_write(8'h01, 16'h8000, 16'h0001, RSP_CORRUPT);

		while (sent_count < ITEM_TARGET) begin
			if (!pressure_done && sent_count >= ITEM_TARGET / 2) begin
				pressure_done = 1'b1;
				push <= 1'b0;
				do begin
					@(negedge clk);
				end while (results_owed != 0);
			end
			quiet <= (sent_count >= 120 && sent_count < 170);
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				run_read(pick8(), pick16(), pick_mode(60, 15, 15));
			end else if (roll < 70) begin
				run_write(pick8(), pick16(), pick16(), pick_mode(60, 0, 25));
			end else if (roll < 85) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1)) begin
						send_rx(pick8(), 1'b0);
					end else begin
						junk = random_item();
						junk.req_type = REQ_UNUSED;
						send_item(junk, 1'b0);
					end
				end
			end else begin
				send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, pick8(), pick16(),
					pick16());
			end
		end

		push <= 1'b0;
		do begin
			@(negedge clk);
		end while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
